// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the waveform generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// Condition must never be seen.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ----- rtl/dwg_pkg.sv -----
// Shared types and constants of the waveform generator.
package dwg_pkg;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned OUT_DATA_W = 24;

  localparam int unsigned TABLE_ENTRIES_DEF = 360;
  localparam int unsigned FRACTION_BITS_DEF = 23;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

  localparam logic [PHASE_W-1:0]  PHASE_STEP_RST = 32'd30129654;
  localparam logic [SAMPLE_W-1:0] MIDPOINT_RST   = 12'd1862;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_FILL    = 2'd1,
    OP_TICK    = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP  = 2'd0,
    REG_WAVE_SELECT = 2'd1,
    REG_AMP_HALF    = 2'd2,
    REG_MIDPOINT    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                wr_en;
    logic                wr_pick;
    logic [IDX_W-1:0]    wr_index;
    logic [SAMPLE_W-1:0] wr_value;
    logic                rd_pick;
    logic [IDX_W-1:0]    rd_index;
  } wave_req_t;

endpackage

// ----- rtl/dwg_wave_table.sv -----
// Two loadable waveform tables in one memory with a registered read port.
module dwg_wave_table #(
  parameter int unsigned TABLE_ENTRIES = dwg_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  dwg_pkg::wave_req_t            req_i,
  output logic [dwg_pkg::SAMPLE_W-1:0]  rd_data_o
);
  import dwg_pkg::*;

  localparam int unsigned AW        = $clog2(TABLE_ENTRIES);
  localparam int unsigned MEM_DEPTH = 2 << AW;

  logic [SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[{req_i.wr_pick, req_i.wr_index[AW-1:0]}] <= req_i.wr_value;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[{req_i.rd_pick, req_i.rd_index[AW-1:0]}];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/dds_wave_generator_with_fifo_unit.sv -----
// Top level of the DDS waveform generator with sample FIFO.
//
// A word on the input stream carries one command: table load, fill one sample, sample tick
// or restart; every command returns exactly one status word on the output stream. Load and
// tick pass from acceptance through the finish state to a result in the output register.
// A fill that finds room reads the table memory, then makes one pass through the shared
// compare-subtract unit for the phase wrap, then finishes; a fill on a full FIFO goes
// straight to the finish state. Restart runs that read and wrap sequence once for each of
// the FIFO_DEPTH-1 prefilled samples. A result waits in the finish state while the output
// register still holds an unaccepted word. After reset and after every write of phase_step
// the block reduces the step modulo the phase limit on the same compare-subtract unit (for
// a smaller limit, by conditional subtracts of the shifted limit); neither the input stream
// nor the configuration port is ready during that time. The input stream takes a word only
// while no command is in work and the configuration port is not writing.
`include "assert_macros.svh"

module dds_wave_generator_with_fifo_unit #(
  parameter int unsigned TABLE_ENTRIES = dwg_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned FRACTION_BITS = dwg_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dwg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dwg_pkg::PHASE_W-1:0]     cfg_data_i,
  // command stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: request_flag[0], table_pick[1], entry_index[10:2], entry_value[22:11], zero[23]
  input  logic [dwg_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [dwg_pkg::OPCODE_W-1:0]    s_axis_tuser,
  // status stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: dac_value[11:0], dac_valid[12], underflow_seen[13], spurious_seen[14],
  //        fifo_level[16:15], zero[23:17]
  output logic [dwg_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import dwg_pkg::*;

  localparam logic [PHASE_W:0] PHASE_LIMIT = (PHASE_W+1)'(TABLE_ENTRIES) << FRACTION_BITS;
  localparam int unsigned      LIMIT_BITS  = $clog2(PHASE_LIMIT + 1);
  localparam int unsigned      RED_LAST    = (LIMIT_BITS >= PHASE_W) ? 0
                                                                    : PHASE_W - LIMIT_BITS;
  localparam int unsigned      BIT_W       = $clog2(PHASE_W);
  localparam logic [PTR_W-1:0] PREFILL_LAST = PTR_W'(FIFO_DEPTH - 2);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_READ   = 5'b00100,
    S_GEN    = 5'b01000,
    S_FIN    = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [PHASE_W-1:0]   step_red_q, step_red_d;
  logic [BIT_W-1:0]     bit_q, bit_d;
  logic                 wave_sel_q, wave_sel_d;
  logic                 amp_half_q, amp_half_d;
  logic [SAMPLE_W-1:0]  midpoint_q, midpoint_d;
  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]     gen_cnt_q, gen_cnt_d;
  logic                 under_q, under_d;
  logic                 spur_q, spur_d;
  logic [SAMPLE_W-1:0]  res_dac_q, res_dac_d;
  logic                 res_valid_q, res_valid_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [SAMPLE_W-1:0]  fifo_q [FIFO_DEPTH];

  logic                 in_accept, cfg_accept, fifo_we, fifo_full;
  logic [SAMPLE_W-1:0]  fifo_wdata, rd_data, gen_sample;
  logic [SAMPLE_W:0]    half_sum;
  logic [PHASE_W:0]     phase_sum, csub_a, csub_b, csub_y;
  logic [PHASE_W-1:0]   pos_full;
  logic [PTR_W-1:0]     fifo_level;
  op_e                  op;
  logic                 in_request, in_pick;
  logic [IDX_W-1:0]     in_index;
  logic [SAMPLE_W-1:0]  in_value;
  wave_req_t            wave_req;

  assign op         = op_e'(s_axis_tuser);
  assign in_request = s_axis_tdata[0];
  assign in_pick    = s_axis_tdata[1];
  assign in_index   = s_axis_tdata[10:2];
  assign in_value   = s_axis_tdata[22:11];

  assign cfg_ready_o   = (state_q == S_IDLE);
  assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_accept    = cfg_valid_i && cfg_ready_o;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign fifo_full  = (wr_ptr_q + 1'b1) == rd_ptr_q;
  assign fifo_level = wr_ptr_q - rd_ptr_q;

  // shared compare-subtract unit: step reduction and phase wrap
  assign phase_sum = {1'b0, phase_q} + {1'b0, step_red_q};
  assign csub_a    = (state_q == S_REDUCE) ? {1'b0, step_red_q} : phase_sum;
  assign csub_b    = (state_q == S_REDUCE) ? (PHASE_LIMIT << bit_q) : PHASE_LIMIT;
  assign csub_y    = (csub_a >= csub_b) ? (csub_a - csub_b) : csub_a;

  assign pos_full = phase_q >> FRACTION_BITS;

  always_comb begin
    wave_req.wr_en    = in_accept && (op == OP_LOAD)
                        && ({1'b0, in_index} < (IDX_W+1)'(TABLE_ENTRIES));
    wave_req.wr_pick  = in_pick;
    wave_req.wr_index = in_index;
    wave_req.wr_value = in_value;
    wave_req.rd_pick  = wave_sel_q;
    wave_req.rd_index = (pos_full < PHASE_W'(TABLE_ENTRIES)) ? pos_full[IDX_W-1:0] : '0;
  end

  dwg_wave_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i    (clk_i),
    .req_i    (wave_req),
    .rd_data_o(rd_data)
  );

  assign half_sum   = {1'b0, rd_data} + {1'b0, midpoint_q};
  assign gen_sample = amp_half_q ? half_sum[SAMPLE_W:1] : rd_data;

  always_comb begin
    state_d     = state_q;
    step_red_d  = step_red_q;
    bit_d       = bit_q;
    wave_sel_d  = wave_sel_q;
    amp_half_d  = amp_half_q;
    midpoint_d  = midpoint_q;
    phase_d     = phase_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    gen_cnt_d   = gen_cnt_q;
    under_d     = under_q;
    spur_d      = spur_q;
    res_dac_d   = res_dac_q;
    res_valid_d = res_valid_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    fifo_we     = 1'b0;
    fifo_wdata  = gen_sample;

    if (cfg_accept) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PHASE_STEP: begin
          step_red_d = cfg_data_i;
          bit_d      = BIT_W'(RED_LAST);
          state_d    = S_REDUCE;
        end
        REG_WAVE_SELECT: wave_sel_d = cfg_data_i[0];
        REG_AMP_HALF:    amp_half_d = cfg_data_i[0];
        REG_MIDPOINT:    midpoint_d = cfg_data_i[SAMPLE_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_dac_d   = '0;
          res_valid_d = 1'b0;
          state_d     = S_FIN;
          unique case (op)
            OP_LOAD: ;
            OP_FILL: begin
              if (!fifo_full) begin
                gen_cnt_d = '0;
                state_d   = S_READ;
              end
            end
            OP_TICK: begin
              priority if (!in_request) begin
                spur_d = 1'b1;
              end else if (rd_ptr_q != wr_ptr_q) begin
                res_dac_d   = fifo_q[rd_ptr_q];
                res_valid_d = 1'b1;
                rd_ptr_d    = rd_ptr_q + 1'b1;
              end else begin
                under_d = 1'b1;
              end
            end
            OP_RESTART: begin
              phase_d   = '0;
              rd_ptr_d  = '0;
              wr_ptr_d  = '0;
              gen_cnt_d = PREFILL_LAST;
              state_d   = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_REDUCE: begin
        step_red_d = csub_y[PHASE_W-1:0];
        bit_d      = bit_q - 1'b1;
        if (bit_q == '0) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        state_d = S_GEN;
      end
      S_GEN: begin
        fifo_we   = 1'b1;
        wr_ptr_d  = wr_ptr_q + 1'b1;
        phase_d   = csub_y[PHASE_W-1:0];
        gen_cnt_d = gen_cnt_q - 1'b1;
        state_d   = (gen_cnt_q == '0) ? S_FIN : S_READ;
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_DATA_W'({fifo_level, spur_q, under_q, res_valid_q, res_dac_q});
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_REDUCE;
      step_red_q  <= PHASE_STEP_RST;
      bit_q       <= BIT_W'(RED_LAST);
      wave_sel_q  <= 1'b0;
      amp_half_q  <= 1'b0;
      midpoint_q  <= MIDPOINT_RST;
      phase_q     <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      gen_cnt_q   <= '0;
      under_q     <= 1'b0;
      spur_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_red_q  <= step_red_d;
      bit_q       <= bit_d;
      wave_sel_q  <= wave_sel_d;
      amp_half_q  <= amp_half_d;
      midpoint_q  <= midpoint_d;
      phase_q     <= phase_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      gen_cnt_q   <= gen_cnt_d;
      under_q     <= under_d;
      spur_q      <= spur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_dac_q   <= res_dac_d;
    res_valid_q <= res_valid_d;
    out_data_q  <= out_data_d;
    if (fifo_we) begin
      fifo_q[wr_ptr_q] <= fifo_wdata;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `ASSERT_NEVER(a_phase_in_range, clk_i, rst_ni, ({1'b0, phase_q} >= PHASE_LIMIT),
                "phase left the table range")
  `ASSERT_NEXT(a_step_reduced, clk_i, rst_ni, ((state_q == S_REDUCE) && (bit_q == '0)),
               ({1'b0, step_red_q} < PHASE_LIMIT), "phase step not reduced below limit")
  `ASSERT_IMPLIES(a_no_push_full, clk_i, rst_ni, (state_q == S_GEN), (!fifo_full),
                  "sample pushed into a full FIFO")

endmodule
